FILE: hw/rtl/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// shared types and codes of the keyed count table
// ----------------------------------------------------------------------------
package kct_pkg;

    // default number of table slots
    localparam int SLOTS_DEF = 16;

    // operation codes; the fourth code behaves as a query
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // one table entry
    typedef struct packed {
        logic [7:0]  key;
        logic [15:0] count;
    } t_slot;

    // decision handed from the arithmetic unit to the sequencer
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] done_amount;
        logic [15:0] held_count;
        logic        upd;      // rewrite count of the matching slot
        logic        append;   // write a new slot at the end of the list
        logic        free;     // drop the matching slot and compact
        logic [15:0] count;    // count to write for upd or append
    } t_act;

endpackage

FILE: hw/rtl/kct_arith.sv
// ----------------------------------------------------------------------------
// kct_arith
// add, subtract and compare unit that decides the outcome of one word
// ----------------------------------------------------------------------------
module kct_arith (
    input  logic [1:0]    i_op,
    input  logic [15:0]   i_amount,
    input  logic          i_found,
    input  logic [15:0]   i_hit_count,
    input  logic          i_full,
    output kct_pkg::t_act o_act
);

    logic [16:0] sum;
    logic [16:0] diff;
    logic [15:0] sat;

    assign sum  = {1'b0, i_hit_count} + {1'b0, i_amount};
    assign diff = {1'b0, i_hit_count} - {1'b0, i_amount};
    assign sat  = sum[16] ? kct_pkg::COUNT_MAX : sum[15:0];

    always_comb begin
        o_act = '0;
        o_act.status = kct_pkg::ST_OK;
        case (i_op)
            kct_pkg::OP_ADD: begin
                if (i_amount == 16'd0) begin
                    o_act.held_count = i_found ? i_hit_count : 16'd0;
                end else if (i_found) begin
                    o_act.upd         = 1'b1;
                    o_act.count       = sat;
                    // saturated part added is max minus old count
                    o_act.done_amount = sum[16] ? ~i_hit_count : i_amount;
                    o_act.held_count  = sat;
                end else if (i_full) begin
                    o_act.status = kct_pkg::ST_FULL;
                end else begin
                    o_act.append      = 1'b1;
                    o_act.count       = i_amount;
                    o_act.done_amount = i_amount;
                    o_act.held_count  = i_amount;
                end
            end
            kct_pkg::OP_REMOVE: begin
                if (!i_found) begin
                    o_act.status = kct_pkg::ST_MISSING;
                end else if (diff[16]) begin
                    o_act.status     = kct_pkg::ST_SHORT;
                    o_act.held_count = i_hit_count;
                end else if (diff[15:0] == 16'd0) begin
                    o_act.free        = 1'b1;
                    o_act.done_amount = i_amount;
                end else begin
                    o_act.upd         = 1'b1;
                    o_act.count       = diff[15:0];
                    o_act.done_amount = i_amount;
                    o_act.held_count  = diff[15:0];
                end
            end
            default: begin
                if (i_found) begin
                    o_act.held_count = i_hit_count;
                end else begin
                    o_act.status = kct_pkg::ST_MISSING;
                end
            end
        endcase
    end

endmodule

FILE: hw/rtl/keyed_count_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_count_table_unit
// packed table of item keys with saturating counts: add, remove, query
// ----------------------------------------------------------------------------
// one word is taken at a time. the key search walks the occupied slots one per
// cycle through a table memory with one read port, one write port and
// registered read data; it stops early on a hit and is skipped on an empty
// table. the unit then decides and writes; when a remove frees a slot that is
// not the last, the last slot is read and copied into the hole. the result
// then goes to the output register once the previous word has left it. a
// finished result waits in the output register while the next word is already
// accepted. there is no clearing pass: only slots below the fill count are
// ever compared or copied.
module keyed_count_table_unit #(
    parameter int SLOTS = kct_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_item_type,
    input  logic [15:0] i_amount,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_done_amount,
    output logic [15:0] o_held_count
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // slot address
    localparam int IW = $clog2(SLOTS + 1);                  // fill count

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_FINISH
    } t_state;

    // table memory, entries at and above the fill count are dead
    kct_pkg::t_slot mem [SLOTS];
    kct_pkg::t_slot r_rd;

    t_state         r_state;
    logic [IW-1:0]  r_used;
    logic [IW-1:0]  r_idx;        // next slot to read during the search
    logic [AW-1:0]  r_rd_idx;     // slot whose data sits in r_rd
    logic           r_pend;       // r_rd holds a slot to compare
    logic           r_found;
    logic [AW-1:0]  r_hit_idx;
    logic [15:0]    r_hit_count;

    // latched word
    logic [1:0]     r_op;
    logic [7:0]     r_key;
    logic [15:0]    r_amount;

    // result waiting for the output register
    logic [1:0]     r_res_status;
    logic [15:0]    r_res_done;
    logic [15:0]    r_res_held;

    // output register
    logic           r_out_valid;
    logic [1:0]     r_out_status;
    logic [15:0]    r_out_done;
    logic [15:0]    r_out_held;

    logic           in_acc;
    logic           out_load;
    logic           full;
    logic [AW-1:0]  rd_addr;
    logic           we;
    logic [AW-1:0]  waddr;
    kct_pkg::t_slot wdata;
    kct_pkg::t_act  act;
    logic [IW-1:0]  last_idx;

    assign o_in_ready    = (r_state == S_IDLE);
    assign in_acc        = i_in_valid && o_in_ready;
    // output register takes the finished result once the previous word is gone
    assign out_load      = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
    assign full          = (r_used == IW'(SLOTS));
    assign last_idx      = r_used - IW'(1);

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_done_amount = r_out_done;
    assign o_held_count  = r_out_held;

    // shared add / subtract / compare unit
    kct_arith u_arith (
        .i_op        (r_op),
        .i_amount    (r_amount),
        .i_found     (r_found),
        .i_hit_count (r_hit_count),
        .i_full      (full),
        .o_act       (act)
    );

    // memory read address: search walk, or the last slot for compaction
    always_comb begin
        rd_addr = '0;
        if (r_state == S_MOVE_RD) begin
            rd_addr = r_used[AW-1:0];
        end else if (r_idx < r_used) begin
            rd_addr = r_idx[AW-1:0];
        end
    end

    // memory write: count update, append, or copy of the last slot
    always_comb begin
        we    = 1'b0;
        waddr = r_hit_idx;
        wdata = '{key: r_key, count: act.count};
        if (r_state == S_DECIDE) begin
            if (act.upd) begin
                we = 1'b1;
            end else if (act.append) begin
                we    = 1'b1;
                waddr = r_used[AW-1:0];
            end
        end else if (r_state == S_MOVE_WR) begin
            we    = 1'b1;
            wdata = r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[rd_addr];
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_res_status;
                r_out_done   <= r_res_done;
                r_out_held   <= r_res_held;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op     <= i_op;
                        r_key    <= i_item_type;
                        r_amount <= i_amount;
                        r_idx    <= '0;
                        r_pend   <= 1'b0;
                        r_found  <= 1'b0;
                        // empty table: nothing to search
                        r_state  <= (r_used == '0) ? S_DECIDE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue side
                    r_pend   <= (r_idx < r_used);
                    r_rd_idx <= r_idx[AW-1:0];
                    if (r_idx < r_used) begin
                        r_idx <= r_idx + IW'(1);
                    end
                    // compare side
                    if (r_pend && (r_rd.key == r_key)) begin
                        r_found     <= 1'b1;
                        r_hit_idx   <= r_rd_idx;
                        r_hit_count <= r_rd.count;
                        r_state     <= S_DECIDE;
                    end else if (r_pend && (r_rd_idx == last_idx[AW-1:0])) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_res_status <= act.status;
                    r_res_done   <= act.done_amount;
                    r_res_held   <= act.held_count;
                    if (act.append) begin
                        r_used  <= r_used + IW'(1);
                        r_state <= S_FINISH;
                    end else if (act.free) begin
                        r_used <= last_idx;
                        // freeing the last slot needs no move
                        if (r_hit_idx == last_idx[AW-1:0]) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_MOVE_RD;
                        end
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_MOVE_RD: begin
                    r_state <= S_MOVE_WR;
                end
                S_MOVE_WR: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    // result moves into the output register
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // fill count never passes the table size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= IW'(SLOTS))
        else $error("fill count beyond table size");

    // one word at a time: no second accept right after one
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("word accepted while busy");

    // failed operations report nothing done
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != kct_pkg::ST_OK)) |-> (o_done_amount == 16'd0))
        else $error("failed operation with nonzero amount");

    // table full is only possible with every slot occupied
    a_full_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && act.status == kct_pkg::ST_FULL) |-> full)
        else $error("full status with free slots");

endmodule
